### design/alf_pkg.sv
// ----------------------------------------------------------------------------
// alf_pkg: shared constants and types of the ARGB linear fade
// Fixed point format, divider sizing, opcodes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package alf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CH_W      = 8;
   localparam int LANES     = 4;
   localparam int INT_BITS  = 10;
   localparam int ACC_W     = FRAC_BITS + INT_BITS;
   localparam int QUO_W     = FRAC_BITS + CH_W;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int LEN_W     = 9;

   // step_count / 5 as (s * 205) >> 10, exact for every 8-bit s
   localparam int RECIP_FIFTH = 205;
   localparam int RECIP_SHIFT = 10;
   localparam int PROD_W      = 2 * CH_W;

   localparam logic [CH_W-1:0] STEP_RESET = CH_W'(100);

   typedef logic [LANES-1:0][CH_W-1:0] color_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ADD,
      ST_EMIT,
      ST_EMIT_LAST
   } fsm_state_type;

   typedef struct packed {
      logic start_load;
      logic div_step;
      logic add_step;
      logic out_load;
      logic out_last;
   } cmd_type;

   typedef struct packed {
      logic at_end;
      logic out_free;
   } status_type;

endpackage

### design/alf_req_if.sv
// ----------------------------------------------------------------------------
// alf_req_if: request channel of the ARGB linear fade
// Valid/ready channel carrying one start or tick item per beat.
// ----------------------------------------------------------------------------
interface alf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] from_alpha;
   logic [7:0] from_red;
   logic [7:0] from_green;
   logic [7:0] from_blue;
   logic [7:0] to_alpha;
   logic [7:0] to_red;
   logic [7:0] to_green;
   logic [7:0] to_blue;
   logic       rising;

   modport source (
      output valid, op, from_alpha, from_red, from_green, from_blue,
      output to_alpha, to_red, to_green, to_blue, rising,
      input  ready
   );
   modport sink (
      input  valid, op, from_alpha, from_red, from_green, from_blue,
      input  to_alpha, to_red, to_green, to_blue, rising,
      output ready
   );
endinterface

### design/alf_rsp_if.sv
// ----------------------------------------------------------------------------
// alf_rsp_if: response channel of the ARGB linear fade
// Valid/ready channel carrying one colour beat per fade step.
// ----------------------------------------------------------------------------
interface alf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_alpha;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       last;

   modport source (
      output valid, out_alpha, out_red, out_green, out_blue, last,
      input  ready
   );
   modport sink (
      input  valid, out_alpha, out_red, out_green, out_blue, last,
      output ready
   );
endinterface

### design/alf_ctrl.sv
// ----------------------------------------------------------------------------
// alf_ctrl: fade controller
// Sequences request acceptance, the serial increment division, the tick
// update and the loading of the response register.
// ----------------------------------------------------------------------------
module alf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   input  alf_pkg::status_type  status,
   output alf_pkg::cmd_type     cmd
);

   alf_pkg::fsm_state_type         state_ff, state_in;
   logic                           fading_ff, fading_in;
   logic [alf_pkg::CNT_W-1:0]      cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= alf_pkg::ST_IDLE;
         fading_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         fading_ff <= fading_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fading_in = fading_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         alf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == alf_pkg::OP_START) begin
                  cmd.start_load = 1'b1;
                  fading_in      = 1'b1;
                  cnt_in         = '0;
                  state_in       = alf_pkg::ST_DIVIDE;
               end else if (fading_ff) begin
                  state_in = status.at_end ? alf_pkg::ST_EMIT_LAST : alf_pkg::ST_ADD;
               end
            end
         end
         alf_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == alf_pkg::CNT_W'(alf_pkg::DIV_STEPS - 1)) begin
               state_in = alf_pkg::ST_IDLE;
            end
         end
         alf_pkg::ST_ADD: begin
            cmd.add_step = 1'b1;
            state_in     = alf_pkg::ST_EMIT;
         end
         alf_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = alf_pkg::ST_IDLE;
            end
         end
         alf_pkg::ST_EMIT_LAST: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               fading_in    = 1'b0;
               state_in     = alf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = alf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### design/alf_dp.sv
// ----------------------------------------------------------------------------
// alf_dp: fade datapath
// Step count register, four restoring dividers for the increments, the
// fixed point accumulators, clamping and the response register.
// ----------------------------------------------------------------------------
module alf_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [alf_pkg::CH_W-1:0]           csr_wr_data,
   input  alf_pkg::cmd_type                   cmd,
   output alf_pkg::status_type                status,
   input  alf_pkg::color_type                 src_colour,
   input  alf_pkg::color_type                 dst_colour,
   input  logic                               rise_mode,
   output alf_pkg::color_type                 rsp_color,
   output logic                               rsp_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready
);

   localparam int CH_W  = alf_pkg::CH_W;
   localparam int FB    = alf_pkg::FRAC_BITS;
   localparam int ACC_W = alf_pkg::ACC_W;
   localparam int QUO_W = alf_pkg::QUO_W;
   localparam int LEN_W = alf_pkg::LEN_W;
   localparam int LANES = alf_pkg::LANES;

   logic [CH_W-1:0]                    step_count_ff;
   logic [CH_W-1:0]                    divisor_ff;
   logic [LEN_W-1:0]                   fade_len_ff;
   logic [LEN_W-1:0]                   tick_count_ff;
   logic                               rising_ff;
   alf_pkg::color_type                 target_ff;
   logic [LANES-1:0]                   neg_ff;
   logic [LANES-1:0][CH_W-1:0]         rem_ff;
   logic [LANES-1:0][QUO_W-1:0]        quo_ff;
   logic [LANES-1:0][ACC_W-1:0]        accum_ff;
   alf_pkg::color_type                 out_color_ff;
   logic                               out_last_ff;
   logic                               out_valid_ff;

   logic [CH_W-1:0]                    step_eff;
   logic [alf_pkg::PROD_W-1:0]         fifth_prod;
   alf_pkg::color_type                 clamped;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= alf_pkg::STEP_RESET;
      end else if (csr_wr_en) begin
         step_count_ff <= csr_wr_data;
      end
   end

   assign step_eff   = (step_count_ff == '0) ? CH_W'(1) : step_count_ff;
   assign fifth_prod = alf_pkg::PROD_W'(step_eff) * alf_pkg::PROD_W'(alf_pkg::RECIP_FIFTH);

   // fade length and tick counter
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
      end else if (cmd.start_load || (cmd.out_load && cmd.out_last)) begin
         tick_count_ff <= '0;
      end else if (cmd.add_step) begin
         tick_count_ff <= tick_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_load) begin
         divisor_ff  <= step_eff;
         fade_len_ff <= LEN_W'(step_eff)
                        + LEN_W'(fifth_prod[alf_pkg::PROD_W-1:alf_pkg::RECIP_SHIFT]);
         rising_ff   <= rise_mode;
         target_ff   <= dst_colour;
      end
   end

   // per-lane divider and accumulator
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [CH_W-1:0]  mag;
      logic [CH_W:0]    trial;
      logic             fits;
      logic [ACC_W-1:0] delta_ext;
      logic [ACC_W-FB:0] ipart;
      logic             round_up;
      logic [ACC_W-FB:0] lim;
      logic [ACC_W-FB:0] clip;

      assign mag   = (dst_colour[i] >= src_colour[i]) ? (dst_colour[i] - src_colour[i])
                                                      : (src_colour[i] - dst_colour[i]);
      assign trial = {rem_ff[i], quo_ff[i][QUO_W-1]};
      assign fits  = (trial >= {1'b0, divisor_ff});
      assign delta_ext = ACC_W'(quo_ff[i]);

      always_ff @(posedge clock) begin
         if (cmd.start_load) begin
            neg_ff[i]   <= (dst_colour[i] < src_colour[i]);
            rem_ff[i]   <= '0;
            quo_ff[i]   <= {mag, {FB{1'b0}}};
            accum_ff[i] <= {{(ACC_W-FB-CH_W){1'b0}}, src_colour[i], {FB{1'b0}}};
         end else if (cmd.div_step) begin
            rem_ff[i] <= fits ? CH_W'(trial - {1'b0, divisor_ff}) : trial[CH_W-1:0];
            quo_ff[i] <= {quo_ff[i][QUO_W-2:0], fits};
         end else if (cmd.add_step) begin
            accum_ff[i] <= neg_ff[i] ? (accum_ff[i] - delta_ext) : (accum_ff[i] + delta_ext);
         end
      end

      // integer part truncated toward zero, clamp to target, saturate
      assign round_up = accum_ff[i][ACC_W-1] && (|accum_ff[i][FB-1:0]);
      assign ipart    = {accum_ff[i][ACC_W-1], accum_ff[i][ACC_W-1:FB]}
                        + (ACC_W-FB+1)'(round_up);
      assign lim      = (ACC_W-FB+1)'(target_ff[i]);

      always_comb begin
         clip = ipart;
         if (rising_ff) begin
            if ($signed(ipart) > $signed(lim)) clip = lim;
         end else begin
            if ($signed(ipart) < $signed(lim)) clip = lim;
         end
         priority if (clip[ACC_W-FB]) begin
            clamped[i] = '0;
         end else if (|clip[ACC_W-FB-1:CH_W]) begin
            clamped[i] = '1;
         end else begin
            clamped[i] = clip[CH_W-1:0];
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_color_ff <= cmd.out_last ? target_ff : clamped;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_color       = out_color_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_valid       = out_valid_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.at_end   = (tick_count_ff >= fade_len_ff);

endmodule

### design/argb_linear_fade_core.sv
// ----------------------------------------------------------------------------
// argb_linear_fade_core: four-channel ARGB linear colour fade
// A start beat loads start and target colours and works out the per-step
// increments; each tick beat then returns the next interpolated colour and,
// after the fade length, the exact target marked last.
// ----------------------------------------------------------------------------
// A start beat is accepted and then holds the request side while four
// restoring dividers produce the increments one quotient bit per cycle; a
// start gives no response. An interpolating tick is accepted, accumulated and
// then loaded into the response register; the final tick is accepted and
// then loads the target. Either waits while the sink stalls the response
// register. A tick while idle is taken and dropped. The fade runs step_count
// + step_count/5 interpolating ticks (a step_count of zero counts as one),
// then one tick returns the target with last set.
// step_count changes apply from the next start.
module argb_linear_fade_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [alf_pkg::CH_W-1:0]   csr_wr_data,
   alf_req_if.sink                    req_chan,
   alf_rsp_if.source                  rsp_chan
);

   alf_pkg::cmd_type     cmd;
   alf_pkg::status_type  status;
   alf_pkg::color_type   src_colour;
   alf_pkg::color_type   dst_colour;
   alf_pkg::color_type   rsp_color;
   logic                 ready;

   assign src_colour = {req_chan.from_blue, req_chan.from_green,
                        req_chan.from_red, req_chan.from_alpha};
   assign dst_colour = {req_chan.to_blue, req_chan.to_green,
                        req_chan.to_red, req_chan.to_alpha};

   alf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   alf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .src_colour  (src_colour),
      .dst_colour  (dst_colour),
      .rise_mode   (req_chan.rising),
      .rsp_color   (rsp_color),
      .rsp_last    (rsp_chan.last),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready)
   );

   assign req_chan.ready     = ready;
   assign rsp_chan.out_alpha = rsp_color[0];
   assign rsp_chan.out_red   = rsp_color[1];
   assign rsp_chan.out_green = rsp_color[2];
   assign rsp_chan.out_blue  = rsp_color[3];

endmodule

### design/alf_checker.sv
// ----------------------------------------------------------------------------
// alf_checker: port-level checks of the ARGB linear fade
// Watches the request and response channels of the core.
// ----------------------------------------------------------------------------
module alf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_op,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_alpha,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_last
);

   logic start_beat;

   assign start_beat = req_valid && req_ready && (req_op == alf_pkg::OP_START);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alpha) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // divider busy after a start
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_beat |=> !req_ready)
      else $error("request accepted during increment division");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      start_beat |=> !$rose(rsp_valid))
      else $error("response raised by a start beat");

endmodule

bind argb_linear_fade_core alf_checker u_alf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_op    (req_chan.op),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_alpha (rsp_chan.out_alpha),
   .rsp_red   (rsp_chan.out_red),
   .rsp_green (rsp_chan.out_green),
   .rsp_blue  (rsp_chan.out_blue),
   .rsp_last  (rsp_chan.last)
);
